/* design/hbfd_pkg.sv */
package hbfd_pkg;

  localparam int unsigned CODE_W              = 8;
  localparam int unsigned GROUP_W             = 10;
  localparam int unsigned FRAME_GROUPS        = 768;
  // groups covered by one mask bit at levels one and two, and by one level-three fill byte
  localparam int unsigned L1_GROUPS           = 48;
  localparam int unsigned L2_GROUPS           = 6;
  localparam int unsigned FILL_GROUPS         = 6;
  localparam int unsigned L3_MASK_W           = 6;
  localparam int unsigned BLACK_BIT           = 7;
  localparam int unsigned WHITE_BIT           = 6;
  localparam int unsigned DEF_LEVEL_ONE_BYTES = 2;
  localparam int unsigned DEF_QUEUE_DEPTH     = 4;

  typedef enum logic {
    KIND_WRITE     = 1'b0,
    KIND_FRAME_END = 1'b1
  } kind_t;

  // one decoded item: optional group write(s) then optional frame end
  typedef struct packed {
    logic               has_write;
    logic               fill;       // six groups instead of one
    logic [CODE_W-1:0]  pix;
    logic [GROUP_W-1:0] index;
    logic               frame_end;
  } cmd_t;

endpackage

/* design/hbfd_front.sv */
module hbfd_front #(
  parameter int unsigned LEVEL_ONE_BYTES = hbfd_pkg::DEF_LEVEL_ONE_BYTES
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [hbfd_pkg::CODE_W-1:0] in_code_byte,
  input  logic                        q_full,
  output logic                        q_push,
  output hbfd_pkg::cmd_t              q_data
);
  import hbfd_pkg::*;

  localparam int unsigned CNT_W = (LEVEL_ONE_BYTES > 1) ? $clog2(LEVEL_ONE_BYTES) : 1;
  localparam int unsigned SUM_W = GROUP_W + 1;

  typedef enum logic [1:0] {LVL_ONE, LVL_TWO, LVL_THREE, LVL_FOUR} level_t;

  level_t                 level_r, level_nxt;
  logic [CNT_W-1:0]       l1_cnt_r, l1_cnt_nxt;
  logic [CODE_W-1:0]      p1_r, p1_nxt, p2_r, p2_nxt;
  logic [L3_MASK_W-1:0]   p3_r, p3_nxt;
  logic [3:0]             l1_left_r, l1_left_nxt, l2_left_r, l2_left_nxt;
  logic [2:0]             l3_left_r, l3_left_nxt;
  logic [GROUP_W-1:0]     cursor_r, cursor_nxt;
  logic                   accept;
  logic                   stop;
  cmd_t                   cmd;
  logic [2:0]             inc;
  logic [2:0]             skip3;
  logic [3:0]             skip2, skip1;
  logic [CNT_W:0]         cnt_inc;
  logic [SUM_W-1:0]       sum;

  function automatic logic [2:0] lzc8(input logic [7:0] v);
    logic [2:0] r;
    r = 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (v[i]) r = 3'(7 - i);
    end
    return r;
  endfunction

  function automatic logic [2:0] lzc6(input logic [5:0] v);
    logic [2:0] r;
    r = 3'd0;
    for (int i = 0; i < 6; i++) begin
      if (v[i]) r = 3'(5 - i);
    end
    return r;
  endfunction

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    level_nxt   = level_r;
    l1_cnt_nxt  = l1_cnt_r;
    p1_nxt      = p1_r;
    p2_nxt      = p2_r;
    p3_nxt      = p3_r;
    l1_left_nxt = l1_left_r;
    l2_left_nxt = l2_left_r;
    l3_left_nxt = l3_left_r;
    cmd         = '0;
    cmd.index   = cursor_r;
    inc         = '0;
    skip3       = '0;
    skip2       = '0;
    skip1       = '0;
    stop        = 1'b0;
    cnt_inc     = '0;

    unique case (level_r)
      LVL_ONE: begin
        p1_nxt      = in_code_byte;
        l1_left_nxt = 4'd8;
      end
      LVL_TWO: begin
        p2_nxt      = in_code_byte;
        l2_left_nxt = 4'd8;
      end
      LVL_THREE: begin
        if (in_code_byte[BLACK_BIT] || in_code_byte[WHITE_BIT]) begin
          cmd.has_write = 1'b1;
          cmd.fill      = 1'b1;
          cmd.pix       = in_code_byte[BLACK_BIT] ? '1 : '0;
          inc           = 3'(FILL_GROUPS);
        end else begin
          p3_nxt      = in_code_byte[L3_MASK_W-1:0];
          l3_left_nxt = 3'(L3_MASK_W);
        end
      end
      LVL_FOUR: begin
        cmd.has_write = 1'b1;
        cmd.pix       = in_code_byte;
        inc           = 3'd1;
      end
      default: ;
    endcase

    // settle: skip clear mask bits down to the next set one, all in one pass
    if (p3_nxt != '0) begin
      skip3       = lzc6(p3_nxt);
      p3_nxt      = p3_nxt << ({1'b0, skip3} + 4'd1);
      l3_left_nxt = l3_left_nxt - (skip3 + 3'd1);
      level_nxt   = LVL_FOUR;
      stop        = 1'b1;
    end else begin
      skip3       = l3_left_nxt;
      l3_left_nxt = '0;
    end

    if (!stop) begin
      if (p2_nxt != '0) begin
        skip2       = {1'b0, lzc8(p2_nxt)};
        p2_nxt      = p2_nxt << (skip2 + 4'd1);
        l2_left_nxt = l2_left_nxt - (skip2 + 4'd1);
        level_nxt   = LVL_THREE;
        stop        = 1'b1;
      end else begin
        skip2       = l2_left_nxt;
        l2_left_nxt = '0;
      end
    end

    if (!stop) begin
      if (p1_nxt != '0) begin
        skip1       = {1'b0, lzc8(p1_nxt)};
        p1_nxt      = p1_nxt << (skip1 + 4'd1);
        l1_left_nxt = l1_left_nxt - (skip1 + 4'd1);
        level_nxt   = LVL_TWO;
        stop        = 1'b1;
      end else begin
        skip1       = l1_left_nxt;
        l1_left_nxt = '0;
      end
    end

    if (!stop) begin
      level_nxt = LVL_ONE;
      cnt_inc   = {1'b0, l1_cnt_r} + (CNT_W+1)'(1);
      if (cnt_inc >= (CNT_W+1)'(LEVEL_ONE_BYTES)) begin
        cmd.frame_end = 1'b1;
        l1_cnt_nxt    = '0;
      end else begin
        l1_cnt_nxt = cnt_inc[CNT_W-1:0];
      end
    end

    // total advance stays below one frame, so one wrap suffices
    sum = SUM_W'(cursor_r) + SUM_W'(inc) + SUM_W'(skip3)
        + SUM_W'(skip2) * SUM_W'(L2_GROUPS) + SUM_W'(skip1) * SUM_W'(L1_GROUPS);
    if (sum >= SUM_W'(FRAME_GROUPS)) begin
      cursor_nxt = GROUP_W'(sum - SUM_W'(FRAME_GROUPS));
    end else begin
      cursor_nxt = GROUP_W'(sum);
    end
    if (cmd.frame_end) cursor_nxt = '0;
  end

  assign q_push = accept && (cmd.has_write || cmd.frame_end);
  assign q_data = cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r   <= LVL_ONE;
      l1_cnt_r  <= '0;
      p1_r      <= '0;
      p2_r      <= '0;
      p3_r      <= '0;
      l1_left_r <= '0;
      l2_left_r <= '0;
      l3_left_r <= '0;
      cursor_r  <= '0;
    end else if (accept) begin
      level_r   <= level_nxt;
      l1_cnt_r  <= l1_cnt_nxt;
      p1_r      <= p1_nxt;
      p2_r      <= p2_nxt;
      p3_r      <= p3_nxt;
      l1_left_r <= l1_left_nxt;
      l2_left_r <= l2_left_nxt;
      l3_left_r <= l3_left_nxt;
      cursor_r  <= cursor_nxt;
    end
  end

endmodule

/* design/hbfd_queue.sv */
module hbfd_queue #(
  parameter int unsigned DEPTH = hbfd_pkg::DEF_QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  hbfd_pkg::cmd_t push_data,
  output logic           full,
  input  logic           pop,
  output hbfd_pkg::cmd_t head,
  output logic           empty
);
  import hbfd_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  cmd_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) count_nxt = count_r + CNT_W'(1);
    else if (pop && !push) count_nxt = count_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule

/* design/hbfd_emit.sv */
module hbfd_emit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_empty,
  input  hbfd_pkg::cmd_t               q_head,
  output logic                         q_pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_result_kind,
  output logic [hbfd_pkg::GROUP_W-1:0] out_group_index,
  output logic [hbfd_pkg::CODE_W-1:0]  out_pixel_bits,
  output logic                         out_last
);
  import hbfd_pkg::*;

  logic               busy_r, busy_nxt;
  logic [2:0]         rem_r, rem_nxt;
  logic [GROUP_W-1:0] idx_r, idx_nxt;
  logic [CODE_W-1:0]  pix_r;
  logic               end_r;
  logic               out_valid_r, out_valid_nxt;
  kind_t              kind_r, kind_nxt;
  logic [GROUP_W-1:0] oidx_r, oidx_nxt;
  logic [CODE_W-1:0]  opix_r, opix_nxt;
  logic               olast_r, olast_nxt;

  logic               adv, have, fire, done;
  logic [2:0]         cur_rem;
  logic [GROUP_W-1:0] cur_idx;
  logic [CODE_W-1:0]  cur_pix;
  logic               cur_end;

  // current item comes straight from the queue head when idle: no load bubble
  always_comb begin
    if (busy_r) begin
      cur_rem = rem_r;
      cur_idx = idx_r;
      cur_pix = pix_r;
      cur_end = end_r;
    end else begin
      cur_rem = q_head.has_write ? (q_head.fill ? 3'(FILL_GROUPS) : 3'd1) : 3'd0;
      cur_idx = q_head.index;
      cur_pix = q_head.pix;
      cur_end = q_head.frame_end;
    end
  end

  assign adv   = !out_valid_r || out_ready;
  assign have  = busy_r || !q_empty;
  assign fire  = adv && have;
  assign q_pop = fire && !busy_r;

  always_comb begin
    rem_nxt   = cur_rem;
    idx_nxt   = cur_idx;
    kind_nxt  = KIND_WRITE;
    oidx_nxt  = cur_idx;
    opix_nxt  = cur_pix;
    olast_nxt = 1'b0;
    done      = 1'b0;
    if (cur_rem != 3'd0) begin
      rem_nxt   = cur_rem - 3'd1;
      idx_nxt   = (cur_idx == GROUP_W'(FRAME_GROUPS - 1)) ? '0 : cur_idx + GROUP_W'(1);
      olast_nxt = (cur_rem == 3'd1) && !cur_end;
      done      = olast_nxt;
    end else begin
      kind_nxt  = KIND_FRAME_END;
      oidx_nxt  = '0;
      opix_nxt  = '0;
      olast_nxt = 1'b1;
      done      = 1'b1;
    end
    busy_nxt      = fire ? !done : busy_r;
    out_valid_nxt = fire ? 1'b1 : (adv ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rem_r   <= rem_nxt;
      idx_r   <= idx_nxt;
      pix_r   <= cur_pix;
      end_r   <= cur_end;
      kind_r  <= kind_nxt;
      oidx_r  <= oidx_nxt;
      opix_r  <= opix_nxt;
      olast_r <= olast_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_kind = kind_r;
  assign out_group_index = oidx_r;
  assign out_pixel_bits  = opix_r;
  assign out_last        = olast_r;

endmodule

/* design/hierarchical_bitmask_frame_decoder.sv */
// Decoder for a four-level bitmask delta code of 96x64 one-bit frames, one
// code byte per input item. Each frame holds LEVEL_ONE_BYTES level-one
// bytes; set mask bits call for lower-level bytes, clear bits leave their
// region (384, 48 or 8 pixels) untouched. Results are 8-pixel group writes
// in raster order (group = (y*96 + x)/8, bit 7 = leftmost, 1 = black) and
// one frame-end result after the last level-one bit; out_last flags the
// final result of each byte; bytes with no write and no frame end give none.
// Rate: the front parses any byte in the cycle it is accepted, skipping runs
// of clear mask bits in that same cycle, so in_ready stays high as long as
// the command queue (QUEUE_DEPTH entries) has room. The back end emits one
// result per cycle while out_ready is high: one for a level-four byte,
// six for a level-three fill byte, plus the frame-end result when a byte
// closes the frame; the front takes further bytes while earlier ones wait in
// the queue. A byte's first result passes through the queue, then the output
// registers. No clearing pass after reset.
module hierarchical_bitmask_frame_decoder #(
  parameter int unsigned LEVEL_ONE_BYTES = hbfd_pkg::DEF_LEVEL_ONE_BYTES,
  parameter int unsigned QUEUE_DEPTH     = hbfd_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [hbfd_pkg::CODE_W-1:0]   in_code_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_result_kind,
  output logic [hbfd_pkg::GROUP_W-1:0]  out_group_index,
  output logic [hbfd_pkg::CODE_W-1:0]   out_pixel_bits,
  output logic                          out_last
);
  import hbfd_pkg::*;

  // front -> queue -> emitter
  logic q_full, q_push, q_pop, q_empty;
  cmd_t q_data, q_head;

  hbfd_front #(
    .LEVEL_ONE_BYTES (LEVEL_ONE_BYTES)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_code_byte (in_code_byte),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_data       (q_data)
  );

  hbfd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  hbfd_emit u_emit (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_head          (q_head),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_result_kind (out_result_kind),
    .out_group_index (out_group_index),
    .out_pixel_bits  (out_pixel_bits),
    .out_last        (out_last)
  );

  // frame end always closes its byte's results
  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_kind == KIND_FRAME_END) |-> out_last)
    else $error("frame end without last");

  // frame end carries zero index and pixels
  a_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_kind == KIND_FRAME_END)
      |-> (out_group_index == '0) && (out_pixel_bits == '0))
    else $error("frame end with nonzero payload");

  // results of one byte come out back to back
  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> out_valid)
    else $error("gap inside one item's results");

endmodule
